// ===== design/greedy_word_wrap_line_breaker_core_defines.svh =====
// Assertion macros shared by the line breaker modules.
`ifndef GREEDY_WORD_WRAP_LINE_BREAKER_CORE_DEFINES_SVH
`define GREEDY_WORD_WRAP_LINE_BREAKER_CORE_DEFINES_SVH

// Checked at every clock edge outside reset.
`define GWW_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define GWW_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/gww_pkg.sv =====
// Types and constants of the greedy word wrap line breaker.
package gww_pkg;

	localparam logic       OP_CHAR          = 1'b0;
	localparam logic       OP_END           = 1'b1;
	localparam logic [7:0] NEWLINE_CODE     = 8'd10;
	localparam logic [7:0] SPACE_CODE       = 8'd32;
	localparam logic [11:0] WRAP_WIDTH_RESET = 12'd640;

	localparam int         ADDR_BITS        = 3;
	localparam logic [0:0] REG_WRAP_WIDTH   = 1'b0;

	typedef struct packed {
		logic       op;
		logic [7:0] char_code;
		logic [7:0] char_width;
	} gww_in_t;

	typedef struct packed {
		logic [15:0] line_begin;
		logic [15:0] line_length;
		logic [11:0] line_width;
		logic [5:0]  line_number;
		logic        last_of_run;
	} gww_out_t;

	typedef struct packed {
		logic push0;
		logic push1;
	} gww_push_t;

endpackage

// ===== design/gww_engine.sv =====
// Line state and break decision, one character beat per cycle while accept is high.
`include "greedy_word_wrap_line_breaker_core_defines.svh"

module gww_engine
	import gww_pkg::*;
#(
	parameter int LINE_LIMIT    = 64,
	parameter int POSITION_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  gww_in_t     item,
	input  logic [11:0] wrap_width,
	output gww_push_t   push,
	output gww_out_t    rec0,
	output gww_out_t    rec1
);

	localparam int PB = POSITION_BITS;
	localparam int CW = $clog2(LINE_LIMIT + 1);

	logic [PB-1:0] pos_q, start_q, space_pos_q;
	logic [11:0]   width_q, wbs_q, rest_q;
	logic          space_seen_q;
	logic [CW-1:0] lines_q;

	logic [PB-1:0] pos_n, start_n, space_pos_n;
	logic [11:0]   width_n, wbs_n, rest_n;
	logic          space_seen_n;
	logic [CW-1:0] lines_n;

	logic          room, nonempty0, nonempty1, over0, over1, lim1, lim2, acc;
	logic [12:0]   sum0, sum1;
	logic [PB-1:0] start1;
	logic [11:0]   cur_w;
	logic [31:0]   num0, num1;

	function automatic gww_out_t make_rec(input logic [PB-1:0] start,
		input logic [PB-1:0] len, input logic [11:0] width, input logic [31:0] num);
		gww_out_t r;
		logic [31:0] s32, l32;
		s32 = 32'(start);
		l32 = 32'(len);
		r.line_begin  = s32[15:0];
		r.line_length = l32[15:0];
		r.line_width  = width;
		r.line_number = num[5:0];
		r.last_of_run = 1'b1;
		return r;
	endfunction

	assign room      = lines_q < CW'(LINE_LIMIT);
	assign sum0      = {1'b0, width_q} + {5'b0, item.char_width};
	assign sum1      = {1'b0, rest_q} + {5'b0, item.char_width};
	assign over0     = sum0 > {1'b0, wrap_width};
	assign over1     = sum1 > {1'b0, wrap_width};
	assign start1    = space_pos_q + PB'(1);
	assign nonempty0 = pos_q != start_q;
	assign nonempty1 = pos_q != start1;
	assign lim1      = ({1'b0, lines_q} + (CW+1)'(1)) >= (CW+1)'(LINE_LIMIT);
	assign lim2      = ({1'b0, lines_q} + (CW+1)'(2)) >= (CW+1)'(LINE_LIMIT);
	assign num0      = 32'(lines_q);
	assign num1      = 32'(lines_q) + 32'd1;

	always_comb begin
		pos_n        = pos_q;
		start_n      = start_q;
		space_pos_n  = space_pos_q;
		width_n      = width_q;
		wbs_n        = wbs_q;
		rest_n       = rest_q;
		space_seen_n = space_seen_q;
		push         = '0;
		acc          = 1'b0;
		cur_w        = width_q;
		rec0         = make_rec(start_q, pos_q - start_q, width_q, num0);
		rec1         = make_rec(start1, pos_q - start1, rest_q, num1);
		if (accept) begin
			if (item.op == OP_END) begin
				push.push0   = room && nonempty0;
				pos_n        = '0;
				start_n      = '0;
				space_pos_n  = '0;
				width_n      = '0;
				wbs_n        = '0;
				rest_n       = '0;
				space_seen_n = 1'b0;
			end else if (room) begin
				acc = 1'b1;
				if (item.char_code == NEWLINE_CODE) begin
					push.push0   = 1'b1;
					pos_n        = pos_q + PB'(1);
					start_n      = pos_q + PB'(1);
					width_n      = '0;
					space_seen_n = 1'b0;
					acc          = 1'b0;
				end else if (over0 && nonempty0) begin
					push.push0   = 1'b1;
					space_seen_n = 1'b0;
					if (space_seen_q) begin
						rec0    = make_rec(start_q, space_pos_q - start_q, wbs_q, num0);
						start_n = start1;
						cur_w   = rest_q;
						if (lim1) begin
							acc = 1'b0;
						end else if (over1 && nonempty1) begin
							push.push1 = 1'b1;
							start_n    = pos_q;
							cur_w      = '0;
							if (lim2) begin
								acc = 1'b0;
							end
						end
					end else begin
						start_n = pos_q;
						cur_w   = '0;
						if (lim1) begin
							acc = 1'b0;
						end
					end
					width_n = cur_w;
				end
				if (acc) begin
					width_n = cur_w + {4'b0, item.char_width};
					pos_n   = pos_q + PB'(1);
					if (item.char_code == SPACE_CODE) begin
						space_seen_n = 1'b1;
						space_pos_n  = pos_q;
						wbs_n        = cur_w;
						rest_n       = '0;
					end else begin
						rest_n = rest_q + {4'b0, item.char_width};
					end
				end
			end
		end
		rec0.last_of_run = !push.push1;
		if (accept && item.op == OP_END) begin
			lines_n = '0;
		end else begin
			lines_n = lines_q + CW'(push.push0) + CW'(push.push1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			start_q      <= '0;
			space_pos_q  <= '0;
			width_q      <= '0;
			wbs_q        <= '0;
			rest_q       <= '0;
			space_seen_q <= 1'b0;
			lines_q      <= '0;
		end else begin
			pos_q        <= pos_n;
			start_q      <= start_n;
			space_pos_q  <= space_pos_n;
			width_q      <= width_n;
			wbs_q        <= wbs_n;
			rest_q       <= rest_n;
			space_seen_q <= space_seen_n;
			lines_q      <= lines_n;
		end
	end

	`GWW_ASSERT(a_lines_bounded, lines_q <= CW'(LINE_LIMIT), "line count past limit")
	`GWW_ASSERT(a_end_clears, (accept && item.op == OP_END) |=> (pos_q == '0 && lines_q == '0), "end of text did not clear")
	`GWW_ASSERT(a_two_needs_space, push.push1 |-> (push.push0 && space_seen_q), "second line without space break")

endmodule

// ===== design/gww_queue.sv =====
// Four-entry result queue taking up to two line records per cycle.
`include "greedy_word_wrap_line_breaker_core_defines.svh"

module gww_queue
	import gww_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  gww_push_t push,
	input  gww_out_t  rec0,
	input  gww_out_t  rec1,
	output logic      full,
	output logic      valid,
	input  logic      stall,
	output gww_out_t  data
);

	gww_out_t    mem_q [4];
	logic [1:0]  head_q;
	logic [2:0]  cnt_q;
	logic [1:0]  tail;
	logic        pop;

	assign tail  = head_q + cnt_q[1:0];
	assign valid = cnt_q != 3'd0;
	assign full  = cnt_q > 3'd2;
	assign pop   = valid && !stall;
	assign data  = mem_q[head_q];

	always_ff @(posedge clk) begin
		if (push.push0) begin
			mem_q[tail] <= rec0;
		end
		if (push.push1) begin
			mem_q[tail + 2'd1] <= rec1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			cnt_q  <= '0;
		end else begin
			head_q <= head_q + 2'(pop);
			cnt_q  <= cnt_q + 3'(push.push0) + 3'(push.push1) - 3'(pop);
		end
	end

	`GWW_ASSERT(a_cnt_bounded, cnt_q <= 3'd4, "queue count past depth")
	`GWW_ASSERT(a_no_overflow, push.push0 |-> cnt_q <= 3'd2, "push into queue without room")
	`GWW_ASSERT(a_drain, (cnt_q == 3'd1 && pop && !push.push0) |=> !valid, "queue did not drain")

endmodule

// ===== design/greedy_word_wrap_line_breaker_core.sv =====
// Top level of the greedy word wrap line breaker with its register port.
//
//  channel  | beat carries                      | handshake
//  ---------+-----------------------------------+---------------------------
//  char     | op, char_code, char_width         | char_valid / char_stall
//  line     | start, length, width, number, last| line_valid / line_stall
//  config   | wrap_width at byte address 0      | psel / penable / pwrite
//
// One character beat is taken per cycle while char_stall is low; its line records enter
// the result queue at the same edge and reach the line channel after those ahead of them.
// A beat yields at most two records; the four-entry queue stalls input when it holds more
// than two, so sustained input rate is one beat per cycle while lines drain as fast.
// Reset clears the line state and sets wrap_width to 640.
// A stall on the line channel holds the head record; input stalls once the queue fills.
`include "greedy_word_wrap_line_breaker_core_defines.svh"

module greedy_word_wrap_line_breaker_core
	import gww_pkg::*;
#(
	parameter int LINE_LIMIT    = 64,
	parameter int POSITION_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 char_valid,
	output logic                 char_stall,
	input  gww_in_t              char_data,
	output logic                 line_valid,
	input  logic                 line_stall,
	output gww_out_t             line_data,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	logic [11:0] wrap_width_q;
	logic        accept;
	logic        full;
	gww_push_t   push;
	gww_out_t    rec0, rec1;

	assign pready     = 1'b1;
	assign char_stall = full;
	assign accept     = char_valid && !char_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_width_q <= WRAP_WIDTH_RESET;
		end else if (psel && penable && pwrite && pready
			&& paddr[ADDR_BITS-1:2] == REG_WRAP_WIDTH) begin
			wrap_width_q <= pwdata[11:0];
		end
	end

	always_comb begin
		case (paddr[ADDR_BITS-1:2])
			REG_WRAP_WIDTH: prdata = {20'b0, wrap_width_q};
			default:        prdata = '0;
		endcase
	end

	gww_engine #(
		.LINE_LIMIT   (LINE_LIMIT),
		.POSITION_BITS(POSITION_BITS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (char_data),
		.wrap_width(wrap_width_q),
		.push      (push),
		.rec0      (rec0),
		.rec1      (rec1)
	);

	gww_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.rec0  (rec0),
		.rec1  (rec1),
		.full  (full),
		.valid (line_valid),
		.stall (line_stall),
		.data  (line_data)
	);

endmodule

// ===== sim/greedy_word_wrap_line_breaker_core_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the greedy word wrap line breaker core.
module greedy_word_wrap_line_breaker_core_tb;
	import gww_pkg::*;

	localparam int LINE_LIMIT = 64;
	localparam int POSITION_BITS = 16;
	localparam int DRAIN_CYCLES = 8;
	localparam int TIMEOUT_CYCLES = 5_000_000;
	localparam int PHASE_ITEMS = 230;

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_kind_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic char_valid = 1'b0;
	logic char_stall;
	gww_in_t char_data = '0;
	logic line_valid;
	logic line_stall = 1'b0;
	gww_out_t line_data;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_BITS-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	gww_in_t pending_chars[$];
	gww_out_t expected_lines[$];
	logic char_taken = 1'b0;
	int burst_left = 0;
	int gap_left = 0;
	stall_kind_t stall_kind = STALL_NONE;
	int stall_kind_left = 0;
	int errors = 0;
	int cycles = 0;

	// Predicted state of the line breaker.
	logic [11:0] wrap_limit;
	logic [15:0] pos_now;
	logic [15:0] start_now;
	logic [11:0] width_now;
	logic space_held;
	logic [15:0] space_at;
	logic [11:0] width_to_space;
	logic [7:0] space_px;
	int lines_done;
	int step_records;

	greedy_word_wrap_line_breaker_core #(
		.LINE_LIMIT(LINE_LIMIT),
		.POSITION_BITS(POSITION_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.char_valid(char_valid),
		.char_stall(char_stall),
		.char_data(char_data),
		.line_valid(line_valid),
		.line_stall(line_stall),
		.line_data(line_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial forever #5 clk = ~clk;

	function automatic void flag_error(string msg);
		errors++;
		if (errors <= 10)
			$display("ERROR at %0t: %s", $realtime, msg);
	endfunction

	function automatic string line_text(gww_out_t r);
		return $sformatf("start=%0d length=%0d width=%0d number=%0d last=%0b",
			r.line_begin, r.line_length, r.line_width, r.line_number, r.last_of_run);
	endfunction

	function automatic void clear_text();
		pos_now = '0;
		start_now = '0;
		width_now = '0;
		space_held = 1'b0;
		space_at = '0;
		width_to_space = '0;
		space_px = '0;
		lines_done = 0;
	endfunction

	function automatic void start_line(logic [15:0] at);
		start_now = at;
		width_now = '0;
		space_held = 1'b0;
	endfunction

	function automatic void record_line(logic [15:0] start, logic [15:0] length,
		logic [11:0] px);
		gww_out_t r;
		r.line_begin = start;
		r.line_length = length;
		r.line_width = px;
		r.line_number = 6'(lines_done);
		r.last_of_run = 1'b0;
		expected_lines.push_back(r);
		lines_done++;
		step_records++;
	endfunction

	function automatic void predict_lines(gww_in_t beat);
		logic accept;
		logic [11:0] rest;
		logic [7:0] px;
		gww_out_t r;
		px = beat.char_width;
		step_records = 0;
		if (beat.op == OP_END) begin
			if (lines_done < LINE_LIMIT && pos_now != start_now)
				record_line(start_now, pos_now - start_now, width_now);
			clear_text();
		end else if (lines_done < LINE_LIMIT) begin
			accept = 1'b1;
			if (beat.char_code == NEWLINE_CODE) begin
				record_line(start_now, pos_now - start_now, width_now);
				pos_now = pos_now + 16'd1;
				start_line(pos_now);
				accept = 1'b0;
			end else if (int'(width_now) + int'(px) > int'(wrap_limit) &&
				pos_now != start_now) begin
				if (space_held) begin
					rest = width_now - width_to_space - 12'(space_px);
					record_line(start_now, space_at - start_now, width_to_space);
					start_line(space_at + 16'd1);
					width_now = rest;
					if (lines_done >= LINE_LIMIT) begin
						accept = 1'b0;
					end else if (int'(width_now) + int'(px) > int'(wrap_limit) &&
						pos_now != start_now) begin
						record_line(start_now, pos_now - start_now, width_now);
						start_line(pos_now);
						if (lines_done >= LINE_LIMIT)
							accept = 1'b0;
					end
				end else begin
					record_line(start_now, pos_now - start_now, width_now);
					start_line(pos_now);
					if (lines_done >= LINE_LIMIT)
						accept = 1'b0;
				end
			end
			if (accept) begin
				width_now = width_now + 12'(px);
				if (beat.char_code == SPACE_CODE) begin
					space_held = 1'b1;
					space_at = pos_now;
					width_to_space = width_now - 12'(px);
					space_px = px;
				end
				pos_now = pos_now + 16'd1;
			end
		end
		if (step_records > 0) begin
			r = expected_lines.pop_back();
			r.last_of_run = 1'b1;
			expected_lines.push_back(r);
		end
	endfunction

	function automatic void check_line(gww_out_t got);
		gww_out_t want;
		if (expected_lines.size() == 0) begin
			flag_error({"line record with none expected: ", line_text(got)});
		end else begin
			want = expected_lines.pop_front();
			if (got.line_begin !== want.line_begin || got.line_length !== want.line_length ||
				got.line_width !== want.line_width || got.line_number !== want.line_number ||
				got.last_of_run !== want.last_of_run)
				flag_error({"line record mismatch: expected ", line_text(want),
					", got ", line_text(got)});
		end
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == TIMEOUT_CYCLES) begin
			$display("Verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			char_taken <= char_valid && !char_stall;
			if (line_valid && !line_stall)
				check_line(line_data);
			if (char_valid && !char_stall)
				predict_lines(char_data);
		end
	end

	// A new beat is presented only once the previous one has been taken.
	always @(negedge clk) begin
		if (arst_n && (!char_valid || char_taken)) begin
			if (gap_left > 0 || pending_chars.size() == 0) begin
				char_valid <= 1'b0;
				if (gap_left > 0)
					gap_left <= gap_left - 1;
			end else begin
				char_valid <= 1'b1;
				char_data <= pending_chars.pop_front();
				if (burst_left <= 1) begin
					burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
						: $urandom_range(1, 16);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (stall_kind_left == 0) begin
			stall_kind <= stall_kind_t'($urandom_range(0, 3));
			stall_kind_left <= $urandom_range(20, 200);
		end else begin
			stall_kind_left <= stall_kind_left - 1;
		end
		case (stall_kind)
			STALL_NONE: line_stall <= 1'b0;
			STALL_LIGHT: line_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: line_stall <= ($urandom_range(0, 3) != 0);
			default: line_stall <= (stall_kind_left % 8) < 5;
		endcase
	end

	function automatic void push_char(logic [7:0] code, logic [7:0] px);
		gww_in_t beat;
		beat.op = OP_CHAR;
		beat.char_code = code;
		beat.char_width = px;
		pending_chars.push_back(beat);
	endfunction

	function automatic void push_end();
		gww_in_t beat;
		beat.op = OP_END;
		beat.char_code = 8'($urandom);
		beat.char_width = 8'($urandom);
		pending_chars.push_back(beat);
	endfunction

	function automatic int queue_words(int cw);
		int words;
		int letters;
		int count;
		words = $urandom_range(1, 12);
		count = 0;
		for (int i = 0; i < words; i++) begin
			letters = $urandom_range(1, 8);
			for (int j = 0; j < letters; j++) begin
				push_char(8'($urandom_range(33, 126)), 8'($urandom_range(0, cw)));
				count++;
			end
			if ($urandom_range(0, 9) == 0)
				push_char(NEWLINE_CODE, 8'($urandom_range(0, 255)));
			else
				push_char(SPACE_CODE, 8'($urandom_range(0, cw)));
			count++;
		end
		if ($urandom_range(0, 9) != 0) begin
			push_end();
			count++;
		end
		return count;
	endfunction

	function automatic int queue_noise();
		int count;
		gww_in_t beat;
		count = $urandom_range(1, 30);
		for (int i = 0; i < count; i++) begin
			beat.op = ($urandom_range(0, 19) == 0) ? OP_END : OP_CHAR;
			case ($urandom_range(0, 3))
				0: beat.char_code = NEWLINE_CODE;
				1: beat.char_code = SPACE_CODE;
				default: beat.char_code = 8'($urandom);
			endcase
			beat.char_width = 8'($urandom);
			pending_chars.push_back(beat);
		end
		return count;
	endfunction

	// Enough line breaks to run past the line limit before the text ends.
	function automatic int queue_past_limit(int cw);
		int count;
		count = $urandom_range(100, 160);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 9) < 6)
				push_char(NEWLINE_CODE, 8'($urandom));
			else if ($urandom_range(0, 4) == 0)
				push_char(SPACE_CODE, 8'($urandom_range(0, cw)));
			else
				push_char(8'($urandom_range(33, 126)), 8'($urandom_range(0, cw)));
		end
		push_end();
		return count + 1;
	endfunction

	task automatic wait_drained();
		while (pending_chars.size() != 0 || char_valid)
			@(posedge clk);
		while (expected_lines.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_wrap_width(logic [11:0] value);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {REG_WRAP_WIDTH, 2'b00};
		pwdata = 32'(value);
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		wrap_limit = value;
		@(negedge clk);
		penable = 1'b0;
		pwrite = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[11:0] !== value)
			flag_error($sformatf("wrap_width read back %0d, expected %0d", prdata[11:0], value));
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	initial begin
		int phase_wraps[8];
		int wrap;
		int cw;
		int phase_items;
		phase_wraps = '{4095, 0, 1, 255, 48, 300, -1, -1};
		wrap_limit = WRAP_WIDTH_RESET;
		clear_text();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset width: a break at a space, a newline, then a space break followed by
		// a forced break in one beat, a zero byte and the final flush.
		push_char(8'd97, 8'd150);
		push_char(8'd98, 8'd150);
		push_char(SPACE_CODE, 8'd150);
		push_char(8'd99, 8'd150);
		push_char(8'd100, 8'd150);
		push_char(NEWLINE_CODE, 8'd7);
		push_char(8'd120, 8'd100);
		push_char(SPACE_CODE, 8'd0);
		push_char(8'd121, 8'd255);
		push_char(8'd122, 8'd255);
		push_char(8'd255, 8'd255);
		push_char(8'd0, 8'd255);
		push_end();
		wait_drained();

		// Zero width: an oversized character alone on a line, empty texts and a
		// trailing newline.
		set_wrap_width(12'd0);
		push_char(8'd103, 8'd255);
		push_char(8'd104, 8'd1);
		push_end();
		push_end();
		push_char(NEWLINE_CODE, 8'd0);
		push_end();
		push_char(SPACE_CODE, 8'd0);
		push_char(8'd105, 8'd0);
		push_end();
		wait_drained();

		foreach (phase_wraps[p]) begin
			wrap = (phase_wraps[p] < 0) ? $urandom_range(2, 4094) : phase_wraps[p];
			set_wrap_width(12'(wrap));
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) begin
				cw = wrap / 6;
				if (cw < 1)
					cw = 1;
				if (cw > 255 || $urandom_range(0, 6) == 0)
					cw = 255;
				case ($urandom_range(0, 19))
					0: phase_items += queue_past_limit(cw);
					1, 2, 3, 4: phase_items += queue_noise();
					default: phase_items += queue_words(cw);
				endcase
			end
			wait_drained();
		end

		if (errors == 0 && expected_lines.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
